>>> hdl/ldpc_pkg.sv
// ----------------------------------------------------------------------------
// ldpc_pkg
// Shared types, constants and arithmetic helpers of the levitation controller.
// ----------------------------------------------------------------------------
package ldpc_pkg;

   localparam int SINE_TABLE_DEPTH_DEF = 1024;
   localparam int OUT_LIMIT_DEF        = 6144;
   localparam int LPF_ALPHA_Q24_DEF    = 3337;

   localparam int ACC_W   = 66;
   localparam int OPND_W  = 33;
   localparam int INDEX_W = 3;

   localparam logic [INDEX_W-1:0] REG_TARGET_X = 3'd0;
   localparam logic [INDEX_W-1:0] REG_TARGET_Y = 3'd1;
   localparam logic [INDEX_W-1:0] REG_KP_X     = 3'd2;
   localparam logic [INDEX_W-1:0] REG_KP_Y     = 3'd3;
   localparam logic [INDEX_W-1:0] REG_KD_X     = 3'd4;
   localparam logic [INDEX_W-1:0] REG_KD_Y     = 3'd5;
   localparam logic [INDEX_W-1:0] REG_PI_KP    = 3'd6;
   localparam logic [INDEX_W-1:0] REG_PI_KI    = 3'd7;

   localparam logic signed [15:0] TARGET_X_RST = 16'sd3369;
   localparam logic signed [15:0] TARGET_Y_RST = 16'sd3994;
   localparam logic signed [31:0] KP_X_RST     = 32'sd1310720;
   localparam logic signed [31:0] KP_Y_RST     = 32'sd1310720;
   localparam logic signed [31:0] KD_X_RST     = 32'sd327680;
   localparam logic signed [31:0] KD_Y_RST     = 32'sd524288;
   localparam logic [30:0]        PI_KP_RST    = 31'd51072;
   localparam logic [30:0]        PI_KI_RST    = 31'd11757;

   localparam logic signed [15:0] COS30_Q15 = 16'sd28378;
   localparam logic signed [15:0] SIN30_Q15 = 16'sd16384;

   localparam longint Q30_ONE     = 64'sd1073741824;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint SK [6] = '{156, 110, 72, 42, 20, 6};
   localparam longint CK [6] = '{182, 132, 90, 56, 30, 12};

   typedef struct packed {
      logic signed [15:0] target_x;
      logic signed [15:0] target_y;
      logic signed [31:0] kp_x;
      logic signed [31:0] kp_y;
      logic signed [31:0] kd_x;
      logic signed [31:0] kd_y;
      logic [30:0]        pi_kp;
      logic [30:0]        pi_ki;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [15:0]        elec_angle;
      logic signed [15:0] meas_current_alpha;
      logic signed [15:0] meas_current_beta;
   } item_type;

   typedef struct packed {
      logic signed [15:0] volt_alpha;
      logic signed [15:0] volt_beta;
      logic               clamped_alpha;
      logic               clamped_beta;
   } result_type;

   typedef struct packed {
      logic idle;
      logic done;
   } core_status_type;

   function automatic logic signed [ACC_W-1:0] rnd(input logic signed [ACC_W-1:0] v,
                                                   input int n);
      logic signed [ACC_W-1:0] half;
      half = ACC_W'(1) <<< (n - 1);
      return (v + half) >>> n;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
      if (v > ACC_W'(64'sd2147483647)) begin
         return 32'sh7FFFFFFF;
      end else if (v < -ACC_W'(64'sd2147483648)) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
      if (v > ACC_W'(32767)) begin
         return 16'sh7FFF;
      end else if (v < -ACC_W'(32768)) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   function automatic longint q30_to_q15(input longint v);
      longint r;
      r = (v + 64'sd16384) >>> 15;
      if (r > 32767) begin
         r = 32767;
      end else if (r < -32767) begin
         r = -32767;
      end
      return r;
   endfunction

   // Sine in the upper half, cosine in the lower half, both Q1.15.
   function automatic logic [31:0] sine_cos_entry(input longint unsigned ph);
      longint unsigned frac;
      longint          x;
      longint          x2;
      longint          ts;
      longint          tc;
      longint          s;
      longint          c;
      longint          sn;
      longint          cs;
      logic [1:0]      quad;
      frac = ph & 64'h3FFF_FFFF;
      quad = 2'((ph >> 30) & 64'd3);
      x    = longint'((frac * longint'(HALF_PI_Q30)) >> 30);
      x2   = (x * x) >>> 30;
      ts   = Q30_ONE;
      tc   = Q30_ONE;
      for (int i = 0; i < 6; i++) begin
         ts = Q30_ONE - ((x2 * ts) >>> 30) / SK[i];
         tc = Q30_ONE - ((x2 * tc) >>> 30) / CK[i];
      end
      s = q30_to_q15((x * ts) >>> 30);
      c = q30_to_q15(Q30_ONE - ((x2 * tc) >>> 30) / 2);
      case (quad)
         2'd0: begin sn = s;  cs = c;  end
         2'd1: begin sn = c;  cs = -s; end
         2'd2: begin sn = -s; cs = -c; end
         default: begin sn = -c; cs = s; end
      endcase
      return {sn[15:0], cs[15:0]};
   endfunction

endpackage

>>> hdl/ldpc_mul.sv
// ----------------------------------------------------------------------------
// ldpc_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module ldpc_mul (
   input  logic                                 clock,
   input  logic signed [ldpc_pkg::OPND_W-1:0]   mul_a,
   input  logic signed [ldpc_pkg::OPND_W-1:0]   mul_b,
   output logic signed [ldpc_pkg::ACC_W-1:0]    product
);

   logic signed [ldpc_pkg::ACC_W-1:0] product_ff;
   logic signed [ldpc_pkg::ACC_W-1:0] product_in;

   assign product_in = mul_a * mul_b;
   assign product    = product_ff;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

>>> hdl/ldpc_rom.sv
// ----------------------------------------------------------------------------
// ldpc_rom
// Sine and cosine table of the electrical angle with a registered read.
// ----------------------------------------------------------------------------
module ldpc_rom #(
   parameter int DEPTH = ldpc_pkg::SINE_TABLE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] index,
   output logic signed [15:0]       sin_q15,
   output logic signed [15:0]       cos_q15
);

   logic [31:0] rom_tbl [DEPTH];
   logic [31:0] data_ff;

   for (genvar g = 0; g < DEPTH; g++) begin : g_tbl
      localparam longint unsigned PH = (longint'(g) << 32) / DEPTH;
      assign rom_tbl[g] = ldpc_pkg::sine_cos_entry(PH);
   end

   always_ff @(posedge clock) begin
      data_ff <= rom_tbl[index];
   end

   assign sin_q15 = data_ff[31:16];
   assign cos_q15 = data_ff[15:0];

endmodule

>>> hdl/ldpc_core.sv
// ----------------------------------------------------------------------------
// ldpc_core
// Sequencer and datapath that run one control tick on the shared multiplier.
// ----------------------------------------------------------------------------
module ldpc_core #(
   parameter int SINE_TABLE_DEPTH = ldpc_pkg::SINE_TABLE_DEPTH_DEF,
   parameter int OUT_LIMIT        = ldpc_pkg::OUT_LIMIT_DEF,
   parameter int LPF_ALPHA_Q24    = ldpc_pkg::LPF_ALPHA_Q24_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         ack,
   input  ldpc_pkg::item_type           item,
   input  ldpc_pkg::cfg_type            cfg,
   output ldpc_pkg::core_status_type    status,
   output ldpc_pkg::result_type         result
);

   localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
   localparam int AW    = ldpc_pkg::ACC_W;
   localparam int OW    = ldpc_pkg::OPND_W;
   localparam logic [4:0] LAST_STEP = 5'd17;

   typedef enum logic [1:0] {IDLE, MUL, POST, DONE} state_type;

   state_type state_ff;
   logic [4:0] step_ff;

   logic signed [16:0] ex_ff, ey_ff, lex_ff, ley_ff, lea_ff, leb_ff;
   logic signed [17:0] dx_ff, dy_ff;
   logic signed [15:0] ia_ff, ib_ff, loa_ff, lob_ff, ira_ff, irb_ff;
   logic signed [31:0] sx_ff, sy_ff, fx_ff, fy_ff, fa_ff, fb_ff;
   logic signed [AW-1:0] acc_ff;
   logic [IDX_W-1:0] idx_ff;
   ldpc_pkg::result_type res_ff;

   logic signed [16:0] ex_in, ey_in, ea, eb;
   logic signed [17:0] dea, deb;
   logic [31:0] ang_scaled;
   logic signed [OW-1:0] mul_a, mul_b;
   logic signed [AW-1:0] product, sum_add, sum_sub, lpf_x, lpf_y;
   logic signed [AW-1:0] va, vb, lim;
   logic signed [15:0] sin_q15, cos_q15;

   ldpc_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   ldpc_rom #(.DEPTH(SINE_TABLE_DEPTH)) u_rom (
      .clock   (clock),
      .index   (idx_ff),
      .sin_q15 (sin_q15),
      .cos_q15 (cos_q15)
   );

   assign ex_in      = 17'(item.pos_x) - 17'(cfg.target_x);
   assign ey_in      = 17'(item.pos_y) - 17'(cfg.target_y);
   assign ang_scaled = 32'(item.elec_angle) * 32'(SINE_TABLE_DEPTH);
   assign ea         = 17'(ira_ff) - 17'(ia_ff);
   assign eb         = 17'(irb_ff) - 17'(ib_ff);
   assign dea        = 18'(ea) - 18'(lea_ff);
   assign deb        = 18'(eb) - 18'(leb_ff);
   assign sum_add    = acc_ff + product;
   assign sum_sub    = acc_ff - product;
   assign lpf_x      = AW'(sx_ff) + ldpc_pkg::rnd(product, 24);
   assign lpf_y      = AW'(sy_ff) + ldpc_pkg::rnd(product, 24);
   assign va         = AW'(loa_ff) + ldpc_pkg::rnd(sum_add, 16);
   assign vb         = AW'(lob_ff) + ldpc_pkg::rnd(sum_add, 16);
   assign lim        = AW'(OUT_LIMIT);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (step_ff)
         5'd0: begin
            mul_a = OW'(LPF_ALPHA_Q24);
            mul_b = (OW'(dx_ff) <<< 13) - OW'(sx_ff);
         end
         5'd1: begin
            mul_a = OW'(LPF_ALPHA_Q24);
            mul_b = (OW'(dy_ff) <<< 13) - OW'(sy_ff);
         end
         5'd2:  begin mul_a = OW'(cfg.kp_x); mul_b = OW'(ex_ff); end
         5'd3:  begin mul_a = OW'(cfg.kd_x); mul_b = OW'(sx_ff); end
         5'd4:  begin mul_a = OW'(cfg.kp_y); mul_b = OW'(ey_ff); end
         5'd5:  begin mul_a = OW'(cfg.kd_y); mul_b = OW'(sy_ff); end
         5'd6:  begin mul_a = OW'(fx_ff); mul_b = OW'(ldpc_pkg::COS30_Q15); end
         5'd7:  begin mul_a = OW'(fy_ff); mul_b = OW'(ldpc_pkg::SIN30_Q15); end
         5'd8:  begin mul_a = OW'(fx_ff); mul_b = OW'(ldpc_pkg::SIN30_Q15); end
         5'd9:  begin mul_a = OW'(fy_ff); mul_b = OW'(ldpc_pkg::COS30_Q15); end
         5'd10: begin mul_a = OW'(fa_ff); mul_b = OW'(cos_q15); end
         5'd11: begin mul_a = OW'(fb_ff); mul_b = OW'(sin_q15); end
         5'd12: begin mul_a = OW'(fb_ff); mul_b = OW'(cos_q15); end
         5'd13: begin mul_a = OW'(fa_ff); mul_b = OW'(sin_q15); end
         5'd14: begin mul_a = OW'({1'b0, cfg.pi_kp}); mul_b = OW'(dea); end
         5'd15: begin mul_a = OW'({1'b0, cfg.pi_ki}); mul_b = OW'(ea); end
         5'd16: begin mul_a = OW'({1'b0, cfg.pi_kp}); mul_b = OW'(deb); end
         5'd17: begin mul_a = OW'({1'b0, cfg.pi_ki}); mul_b = OW'(eb); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         step_ff  <= '0;
         lex_ff   <= '0;
         ley_ff   <= '0;
         sx_ff    <= '0;
         sy_ff    <= '0;
         lea_ff   <= '0;
         leb_ff   <= '0;
         loa_ff   <= '0;
         lob_ff   <= '0;
      end else begin
         case (state_ff)
            IDLE: begin
               if (start) begin
                  ex_ff    <= ex_in;
                  ey_ff    <= ey_in;
                  dx_ff    <= 18'(ex_in) - 18'(lex_ff);
                  dy_ff    <= 18'(ey_in) - 18'(ley_ff);
                  lex_ff   <= ex_in;
                  ley_ff   <= ey_in;
                  ia_ff    <= item.meas_current_alpha;
                  ib_ff    <= item.meas_current_beta;
                  idx_ff   <= ang_scaled[16 +: IDX_W];
                  step_ff  <= '0;
                  state_ff <= MUL;
               end
            end
            MUL: begin
               state_ff <= POST;
            end
            POST: begin
               case (step_ff)
                  5'd0:  sx_ff <= ldpc_pkg::sat32(lpf_x);
                  5'd1:  sy_ff <= ldpc_pkg::sat32(lpf_y);
                  5'd3:  fx_ff <= ldpc_pkg::sat32(ldpc_pkg::rnd(
                                     acc_ff + ldpc_pkg::rnd(product, 13), 16));
                  5'd5:  fy_ff <= ldpc_pkg::sat32(ldpc_pkg::rnd(
                                     acc_ff + ldpc_pkg::rnd(product, 13), 16));
                  5'd7:  fa_ff <= ldpc_pkg::sat32(ldpc_pkg::rnd(sum_sub, 15));
                  5'd9:  fb_ff <= ldpc_pkg::sat32(ldpc_pkg::rnd(sum_add, 15));
                  5'd11: ira_ff <= ldpc_pkg::sat16(ldpc_pkg::rnd(sum_add, 15));
                  5'd13: irb_ff <= ldpc_pkg::sat16(ldpc_pkg::rnd(sum_sub, 15));
                  5'd15: begin
                     lea_ff <= ea;
                     if (va > lim) begin
                        loa_ff <= 16'(OUT_LIMIT);
                        res_ff.volt_alpha    <= 16'(OUT_LIMIT);
                        res_ff.clamped_alpha <= 1'b1;
                     end else if (va < -lim) begin
                        loa_ff <= -16'(OUT_LIMIT);
                        res_ff.volt_alpha    <= -16'(OUT_LIMIT);
                        res_ff.clamped_alpha <= 1'b1;
                     end else begin
                        loa_ff <= va[15:0];
                        res_ff.volt_alpha    <= va[15:0];
                        res_ff.clamped_alpha <= 1'b0;
                     end
                  end
                  5'd17: begin
                     leb_ff <= eb;
                     if (vb > lim) begin
                        lob_ff <= 16'(OUT_LIMIT);
                        res_ff.volt_beta    <= 16'(OUT_LIMIT);
                        res_ff.clamped_beta <= 1'b1;
                     end else if (vb < -lim) begin
                        lob_ff <= -16'(OUT_LIMIT);
                        res_ff.volt_beta    <= -16'(OUT_LIMIT);
                        res_ff.clamped_beta <= 1'b1;
                     end else begin
                        lob_ff <= vb[15:0];
                        res_ff.volt_beta    <= vb[15:0];
                        res_ff.clamped_beta <= 1'b0;
                     end
                  end
                  default: acc_ff <= product;
               endcase
               if (step_ff == LAST_STEP) begin
                  state_ff <= DONE;
               end else begin
                  step_ff  <= step_ff + 5'd1;
                  state_ff <= MUL;
               end
            end
            DONE: begin
               if (ack) begin
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign status.idle = (state_ff == IDLE);
   assign status.done = (state_ff == DONE);
   assign result      = res_ff;

endmodule

>>> hdl/dual_axis_levitation_pd_pi_controller_unit.sv
// ----------------------------------------------------------------------------
// dual_axis_levitation_pd_pi_controller_unit
// Cascaded PD position and incremental PI current controller for two axes.
// ----------------------------------------------------------------------------
// One req transaction carries a control tick: both rotor positions, the
// electrical angle and the two measured phase currents. One rsp transaction
// returns the two clamped voltage commands and their clamp flags.
// The tick runs as 18 multiplications on one shared 33 by 33 bit multiplier,
// each taking a MUL state and then a POST state in the sequencer.
// req_tready is high only while the sequencer is idle, so a new tick is not
// taken before the last one has been passed to the output register.
// The result waits in an output register; when the receiver stalls, a
// finished tick holds in the sequencer until that register is free.
// The csr port writes gains and setpoints and should be used
// only while the block is idle.
// Reset restores the default gains and setpoints and clears the filter,
// error and output history of both loops.
// ----------------------------------------------------------------------------
module dual_axis_levitation_pd_pi_controller_unit #(
   parameter int SINE_TABLE_DEPTH = ldpc_pkg::SINE_TABLE_DEPTH_DEF,
   parameter int OUT_LIMIT        = ldpc_pkg::OUT_LIMIT_DEF,
   parameter int LPF_ALPHA_Q24    = ldpc_pkg::LPF_ALPHA_Q24_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // pos_x, pos_y, elec_angle, meas_current_alpha, meas_current_beta
   input  logic [79:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // volt_alpha, volt_beta, clamped_alpha, clamped_beta, zero fill
   output logic [39:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [ldpc_pkg::INDEX_W-1:0] csr_index,
   input  logic [31:0] csr_wdata
);

   ldpc_pkg::cfg_type         cfg_ff;
   ldpc_pkg::item_type        item;
   ldpc_pkg::result_type      result;
   ldpc_pkg::result_type      out_ff;
   ldpc_pkg::core_status_type status;
   logic rsp_valid_ff;
   logic start;
   logic load;

   assign item.pos_x              = req_tdata[15:0];
   assign item.pos_y              = req_tdata[31:16];
   assign item.elec_angle         = req_tdata[47:32];
   assign item.meas_current_alpha = req_tdata[63:48];
   assign item.meas_current_beta  = req_tdata[79:64];

   assign req_tready = status.idle;
   assign start      = req_tvalid & status.idle;
   assign load       = status.done & (~rsp_valid_ff | rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_x <= ldpc_pkg::TARGET_X_RST;
         cfg_ff.target_y <= ldpc_pkg::TARGET_Y_RST;
         cfg_ff.kp_x     <= ldpc_pkg::KP_X_RST;
         cfg_ff.kp_y     <= ldpc_pkg::KP_Y_RST;
         cfg_ff.kd_x     <= ldpc_pkg::KD_X_RST;
         cfg_ff.kd_y     <= ldpc_pkg::KD_Y_RST;
         cfg_ff.pi_kp    <= ldpc_pkg::PI_KP_RST;
         cfg_ff.pi_ki    <= ldpc_pkg::PI_KI_RST;
      end else if (csr_we) begin
         case (csr_index)
            ldpc_pkg::REG_TARGET_X: cfg_ff.target_x <= csr_wdata[15:0];
            ldpc_pkg::REG_TARGET_Y: cfg_ff.target_y <= csr_wdata[15:0];
            ldpc_pkg::REG_KP_X:     cfg_ff.kp_x     <= csr_wdata;
            ldpc_pkg::REG_KP_Y:     cfg_ff.kp_y     <= csr_wdata;
            ldpc_pkg::REG_KD_X:     cfg_ff.kd_x     <= csr_wdata;
            ldpc_pkg::REG_KD_Y:     cfg_ff.kd_y     <= csr_wdata;
            ldpc_pkg::REG_PI_KP:    cfg_ff.pi_kp    <= csr_wdata[30:0];
            ldpc_pkg::REG_PI_KI:    cfg_ff.pi_ki    <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= result;
      end
   end

   ldpc_core #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
      .OUT_LIMIT        (OUT_LIMIT),
      .LPF_ALPHA_Q24    (LPF_ALPHA_Q24)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .ack    (load),
      .item   (item),
      .cfg    (cfg_ff),
      .status (status),
      .result (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, out_ff.clamped_beta, out_ff.clamped_alpha,
                        out_ff.volt_beta, out_ff.volt_alpha};

endmodule
